/* sv/tpg_pkg.sv */
// ---------------------------------------------------------------------------
// tpg_pkg
// Shared constants, codes and types of the transmit permit guard.
// ---------------------------------------------------------------------------
package tpg_pkg;

   localparam int BLOCK_ENTRIES = 16;
   localparam int STAMP_ENTRIES = 16;

   localparam int BLK_IDX_W = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
   localparam int STP_IDX_W = (STAMP_ENTRIES > 1) ? $clog2(STAMP_ENTRIES) : 1;
   localparam int SCAN_W    = (BLK_IDX_W > STP_IDX_W) ? BLK_IDX_W : STP_IDX_W;
   localparam int CNT_W     = $clog2(STAMP_ENTRIES + 1);

   // Field widths.
   localparam int MODE_W    = 3;
   localparam int TIME_W    = 32;
   localparam int FREQ_W    = 22;
   localparam int VERDICT_W = 3;
   localparam int COUNT_W   = 5;
   localparam int MAXW_W    = 5;
   localparam int TOL_W     = 16;

   // Configuration port.
   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_REQ_CONFIRM = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CONF_TMO    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_DUR     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_WINDOW  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 3'd5;

   // Reset values of the registers.
   localparam logic [TIME_W-1:0] RST_CONF_TMO   = 32'd30000;
   localparam logic [TIME_W-1:0] RST_MAX_DUR    = 32'd5000;
   localparam logic [MAXW_W-1:0] RST_MAX_WINDOW = 5'd10;
   localparam logic [TIME_W-1:0] RST_WINDOW     = 32'd60000;
   localparam logic [TOL_W-1:0]  RST_TOLERANCE  = 16'd100;

   // Command modes.
   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RECORD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CONFIRM = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CANCEL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd5;

   // Verdicts.
   localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED    = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_TIMEOUT    = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_CONFIRM = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_BLOCKED    = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_RATE       = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_DURATION   = 3'd5;

   // Operation select of the shared compare unit.
   typedef struct packed {
      logic abs_diff;   // use the magnitude of the difference
      logic less_than;  // test difference < limit instead of difference > limit
   } cmp_ctrl_type;

endpackage

/* sv/tpg_cmp_unit.sv */
// ---------------------------------------------------------------------------
// tpg_cmp_unit
// Shared subtract and compare unit: forms a - b (wrapping, or its magnitude)
// and compares it with a limit.
// ---------------------------------------------------------------------------
module tpg_cmp_unit (
   input  logic [tpg_pkg::TIME_W-1:0] op_a,
   input  logic [tpg_pkg::TIME_W-1:0] op_b,
   input  logic [tpg_pkg::TIME_W-1:0] limit,
   input  tpg_pkg::cmp_ctrl_type      ctrl,
   output logic                       hit
);
   import tpg_pkg::*;

   logic [TIME_W-1:0] diff;

   always_comb begin
      if (ctrl.abs_diff && (op_a < op_b)) begin
         diff = op_b - op_a;
      end else begin
         diff = op_a - op_b;
      end
      if (ctrl.less_than) begin
         hit = (diff < limit);
      end else begin
         hit = (diff > limit);
      end
   end

endmodule

/* sv/transmit_permit_guard_core.sv */
// ---------------------------------------------------------------------------
// transmit_permit_guard_core
// Processing: once an item is accepted, an expiry pass over every stamp entry,
// a decision step, a scan of the blocked table for add, remove and any check
// that the decision passes on (it ends at the lowest match), a rate step for a
// check that the scan does not block, and an output load; the output load also
// waits while an earlier result is still stalled.
// Throughput: one item at a time, next taken the cycle after the result loads.
// Reset (synchronous) restores the register defaults, empties both tables and
// clears the pending confirmation; no clearing pass is needed.
// ---------------------------------------------------------------------------
module transmit_permit_guard_core (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tpg_pkg::MODE_W-1:0]       req_mode,
   input  logic [tpg_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [tpg_pkg::FREQ_W-1:0]       req_frequency_khz,
   input  logic [tpg_pkg::TIME_W-1:0]       req_duration_ms,
   input  logic                             req_confirmed,
   input  logic                             req_was_allowed,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tpg_pkg::VERDICT_W-1:0]    rsp_verdict,
   output logic                             rsp_table_ok,
   output logic [tpg_pkg::COUNT_W-1:0]      rsp_recent_count,
   output logic                             rsp_confirmation_pending,
   output logic                             rsp_transmit_allowed,
   // Configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tpg_pkg::PADDR_W-1:0]      paddr,
   input  logic [tpg_pkg::PDATA_W-1:0]      pwdata,
   output logic [tpg_pkg::PDATA_W-1:0]      prdata,
   output logic                             pready
);
   import tpg_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPIRE = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_RATE   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [7:0] COUNT_SAT = 8'd31;

   // Configuration registers
   logic                req_confirm_ff;
   logic [TIME_W-1:0]   conf_tmo_ff;
   logic [TIME_W-1:0]   max_dur_ff;
   logic [MAXW_W-1:0]   max_window_ff;
   logic [TIME_W-1:0]   window_ff;
   logic [TOL_W-1:0]    tolerance_ff;

   // Sequencer and state
   logic [2:0]          state_ff, state_in;
   logic [SCAN_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;
   logic                ok_ff, ok_in;
   logic                free_found_ff, free_found_in;
   logic [BLK_IDX_W-1:0] free_idx_ff, free_idx_in;
   logic                pending_ff, pending_in;
   logic [TIME_W-1:0]   req_time_ff, req_time_in;
   logic [STP_IDX_W-1:0] ptr_ff, ptr_in;
   logic                stamp_valid_ff [STAMP_ENTRIES];
   logic                stamp_valid_in [STAMP_ENTRIES];
   logic                blocked_valid_ff [BLOCK_ENTRIES];
   logic                blocked_valid_in [BLOCK_ENTRIES];

   // Table contents, meaningful only where the valid bit is set
   logic [TIME_W-1:0]   stamp_time_ff [STAMP_ENTRIES];
   logic [FREQ_W-1:0]   blocked_freq_ff [BLOCK_ENTRIES];
   logic                stamp_we;
   logic                blk_we;
   logic [BLK_IDX_W-1:0] blk_widx;

   // Latched item
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [TIME_W-1:0]   dur_ff, dur_in;
   logic                conf_ff, conf_in;
   logic                allow_ff, allow_in;

   // Output registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_pending_ff, rsp_pending_in;
   logic                rsp_allowed_ff, rsp_allowed_in;

   // Shared compare unit
   logic [TIME_W-1:0]   cmp_a, cmp_b, cmp_lim;
   cmp_ctrl_type        cmp_ctrl;
   logic                cmp_hit;

   logic [STP_IDX_W-1:0] sidx;
   logic [BLK_IDX_W-1:0] bidx;
   logic                count_ge;
   logic                cfg_wr;

   assign sidx     = idx_ff[STP_IDX_W-1:0];
   assign bidx     = idx_ff[BLK_IDX_W-1:0];
   assign count_ge = (8'(count_ff) >= 8'(max_window_ff));

   assign req_stall                = (state_ff != ST_IDLE);
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_verdict              = rsp_verdict_ff;
   assign rsp_table_ok             = rsp_ok_ff;
   assign rsp_recent_count         = rsp_count_ff;
   assign rsp_confirmation_pending = rsp_pending_ff;
   assign rsp_transmit_allowed     = rsp_allowed_ff;

   // ---------------- Configuration port ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_confirm_ff <= 1'b1;
         conf_tmo_ff    <= RST_CONF_TMO;
         max_dur_ff     <= RST_MAX_DUR;
         max_window_ff  <= RST_MAX_WINDOW;
         window_ff      <= RST_WINDOW;
         tolerance_ff   <= RST_TOLERANCE;
      end else if (cfg_wr) begin
         case (paddr[PADDR_W-1:2])
            REG_REQ_CONFIRM: req_confirm_ff <= pwdata[0];
            REG_CONF_TMO:    conf_tmo_ff    <= pwdata;
            REG_MAX_DUR:     max_dur_ff     <= pwdata;
            REG_MAX_WINDOW:  max_window_ff  <= pwdata[MAXW_W-1:0];
            REG_WINDOW:      window_ff      <= pwdata;
            REG_TOLERANCE:   tolerance_ff   <= pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[PADDR_W-1:2])
         REG_REQ_CONFIRM: prdata = PDATA_W'(req_confirm_ff);
         REG_CONF_TMO:    prdata = conf_tmo_ff;
         REG_MAX_DUR:     prdata = max_dur_ff;
         REG_MAX_WINDOW:  prdata = PDATA_W'(max_window_ff);
         REG_WINDOW:      prdata = window_ff;
         REG_TOLERANCE:   prdata = PDATA_W'(tolerance_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------- Compare unit operand selection ----------------
   always_comb begin
      cmp_a    = '0;
      cmp_b    = '0;
      cmp_lim  = '0;
      cmp_ctrl = '{abs_diff: 1'b0, less_than: 1'b0};
      case (state_ff)
         ST_EXPIRE: begin
            cmp_a   = now_ff;
            cmp_b   = stamp_time_ff[sidx];
            cmp_lim = window_ff;
         end
         ST_DECIDE: begin
            cmp_a   = now_ff;
            cmp_b   = req_time_ff;
            cmp_lim = conf_tmo_ff;
         end
         ST_SCAN: begin
            cmp_a    = TIME_W'(freq_ff);
            cmp_b    = TIME_W'(blocked_freq_ff[bidx]);
            cmp_lim  = TIME_W'(tolerance_ff);
            cmp_ctrl = '{abs_diff: 1'b1, less_than: 1'b1};
         end
         ST_RATE: begin
            cmp_a   = dur_ff;
            cmp_lim = max_dur_ff;
         end
         default: ;
      endcase
   end

   tpg_cmp_unit u_cmp (
      .op_a  (cmp_a),
      .op_b  (cmp_b),
      .limit (cmp_lim),
      .ctrl  (cmp_ctrl),
      .hit   (cmp_hit)
   );

   // ---------------- Sequencer ----------------
   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      count_in         = count_ff;
      verdict_in       = verdict_ff;
      ok_in            = ok_ff;
      free_found_in    = free_found_ff;
      free_idx_in      = free_idx_ff;
      pending_in       = pending_ff;
      req_time_in      = req_time_ff;
      ptr_in           = ptr_ff;
      stamp_valid_in   = stamp_valid_ff;
      blocked_valid_in = blocked_valid_ff;
      stamp_we         = 1'b0;
      blk_we           = 1'b0;
      blk_widx         = bidx;
      mode_in          = mode_ff;
      now_in           = now_ff;
      freq_in          = freq_ff;
      dur_in           = dur_ff;
      conf_in          = conf_ff;
      allow_in         = allow_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_verdict_in   = rsp_verdict_ff;
      rsp_ok_in        = rsp_ok_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_pending_in   = rsp_pending_ff;
      rsp_allowed_in   = rsp_allowed_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               now_in        = req_now_ms;
               freq_in       = req_frequency_khz;
               dur_in        = req_duration_ms;
               conf_in       = req_confirmed;
               allow_in      = req_was_allowed;
               idx_in        = '0;
               count_in      = '0;
               verdict_in    = VERDICT_ALLOWED;
               ok_in         = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            // Drop a timestamp once its wrapping age exceeds the window.
            if (stamp_valid_ff[sidx]) begin
               if (cmp_hit) begin
                  stamp_valid_in[sidx] = 1'b0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (idx_ff == SCAN_W'(STAMP_ENTRIES - 1)) begin
               idx_in   = '0;
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            case (mode_ff)
               MODE_CHECK: begin
                  if (pending_ff && cmp_hit) begin
                     pending_in = 1'b0;
                     verdict_in = VERDICT_TIMEOUT;
                  end else if (req_confirm_ff && !conf_ff) begin
                     verdict_in = VERDICT_NO_CONFIRM;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               MODE_RECORD: begin
                  if (allow_ff) begin
                     // The new stamp has age zero, so it is always inside the window.
                     stamp_we               = 1'b1;
                     stamp_valid_in[ptr_ff] = 1'b1;
                     if (!stamp_valid_ff[ptr_ff]) begin
                        count_in = count_ff + 1'b1;
                     end
                     if (ptr_ff == STP_IDX_W'(STAMP_ENTRIES - 1)) begin
                        ptr_in = '0;
                     end else begin
                        ptr_in = ptr_ff + 1'b1;
                     end
                  end
               end
               MODE_CONFIRM: begin
                  pending_in  = 1'b1;
                  req_time_in = now_ff;
               end
               MODE_CANCEL: begin
                  pending_in  = 1'b0;
                  req_time_in = '0;
               end
               MODE_ADD, MODE_REMOVE: begin
                  state_in = ST_SCAN;
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (blocked_valid_ff[bidx] && cmp_hit) begin
               // The lowest matching entry ends the scan.
               case (mode_ff)
                  MODE_CHECK: verdict_in = VERDICT_BLOCKED;
                  MODE_REMOVE: begin
                     blocked_valid_in[bidx] = 1'b0;
                     ok_in                  = 1'b1;
                  end
                  default: ;
               endcase
               state_in = ST_FINISH;
            end else begin
               if (!blocked_valid_ff[bidx] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = bidx;
               end
               if (idx_ff == SCAN_W'(BLOCK_ENTRIES - 1)) begin
                  idx_in   = '0;
                  state_in = ST_FINISH;
                  if (mode_ff == MODE_CHECK) begin
                     state_in = ST_RATE;
                  end else if ((mode_ff == MODE_ADD) && free_found_in) begin
                     blk_we                     = 1'b1;
                     blk_widx                   = free_found_ff ? free_idx_ff : bidx;
                     blocked_valid_in[blk_widx] = 1'b1;
                     ok_in                      = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_RATE: begin
            if (count_ge) begin
               verdict_in = VERDICT_RATE;
            end else if (cmp_hit) begin
               verdict_in = VERDICT_DURATION;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_ok_in      = ok_ff;
               rsp_count_in   = (8'(count_ff) > COUNT_SAT) ? COUNT_W'(COUNT_SAT)
                                                           : COUNT_W'(count_ff);
               rsp_pending_in = pending_ff;
               rsp_allowed_in = !pending_ff && !count_ge;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         idx_ff           <= '0;
         count_ff         <= '0;
         verdict_ff       <= VERDICT_ALLOWED;
         ok_ff            <= 1'b0;
         free_found_ff    <= 1'b0;
         free_idx_ff      <= '0;
         pending_ff       <= 1'b0;
         req_time_ff      <= '0;
         ptr_ff           <= '0;
         stamp_valid_ff   <= '{default: 1'b0};
         blocked_valid_ff <= '{default: 1'b0};
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         idx_ff           <= idx_in;
         count_ff         <= count_in;
         verdict_ff       <= verdict_in;
         ok_ff            <= ok_in;
         free_found_ff    <= free_found_in;
         free_idx_ff      <= free_idx_in;
         pending_ff       <= pending_in;
         req_time_ff      <= req_time_in;
         ptr_ff           <= ptr_in;
         stamp_valid_ff   <= stamp_valid_in;
         blocked_valid_ff <= blocked_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      now_ff         <= now_in;
      freq_ff        <= freq_in;
      dur_ff         <= dur_in;
      conf_ff        <= conf_in;
      allow_ff       <= allow_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_allowed_ff <= rsp_allowed_in;
      if (stamp_we) begin
         stamp_time_ff[ptr_ff] <= now_ff;
      end
      if (blk_we) begin
         blocked_freq_ff[blk_widx] <= freq_ff;
      end
   end

endmodule

/* sv/tpg_checker.sv */
// ---------------------------------------------------------------------------
// tpg_checker
// Port-level checks on the transmit permit guard, bound to the top level.
// ---------------------------------------------------------------------------
module tpg_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tpg_pkg::VERDICT_W-1:0] rsp_verdict,
   input  logic                          rsp_table_ok,
   input  logic                          rsp_confirmation_pending,
   input  logic                          rsp_transmit_allowed
);
   import tpg_pkg::*;

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");

   // A permitted transmit needs no pending confirmation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transmit_allowed |-> !rsp_confirmation_pending)
      else $error("transmit allowed with confirmation pending");

   // A timed-out confirmation is no longer pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_TIMEOUT) |-> !rsp_confirmation_pending)
      else $error("timeout left confirmation pending");

   // A check result never reports a table edit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict != VERDICT_ALLOWED) |-> !rsp_table_ok)
      else $error("table edit reported with a check verdict");

endmodule

bind transmit_permit_guard_core tpg_checker u_tpg_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_valid                (req_valid),
   .req_stall                (req_stall),
   .rsp_valid                (rsp_valid),
   .rsp_stall                (rsp_stall),
   .rsp_verdict              (rsp_verdict),
   .rsp_table_ok             (rsp_table_ok),
   .rsp_confirmation_pending (rsp_confirmation_pending),
   .rsp_transmit_allowed     (rsp_transmit_allowed)
);
